// ===== sv/rgpg_pkg.sv =====
// shared constants, types and constant functions for the radial gradient generator
`default_nettype none

package rgpg_pkg;

  localparam int MaxSize   = 4096;
  localparam int SizeW     = 13;
  localparam int CoordW    = 12;
  localparam int ColorW    = 8;
  localparam int FalloffW  = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int NxW       = 15;
  localparam int SqW       = 27;
  localparam int SsW       = 25;
  localparam int QW        = 32;
  localparam int DW        = 16;
  localparam int PW        = 17;
  localparam int NlW       = 21;
  localparam int EW        = 24;
  localparam int MantW     = 31;
  localparam int AccW      = 33;
  localparam int FracW     = 16;
  localparam int DivSteps  = 32;
  localparam int SqrtSteps = 16;
  localparam int LogSteps  = 16;
  localparam int ExpSteps  = 16;

  localparam logic [PW-1:0] POne = 17'h10000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SIZE         = 3'd0,
    REG_CENTER_RED   = 3'd1,
    REG_CENTER_GREEN = 3'd2,
    REG_CENTER_BLUE  = 3'd3,
    REG_EDGE_RED     = 3'd4,
    REG_EDGE_GREEN   = 3'd5,
    REG_EDGE_BLUE    = 3'd6,
    REG_FALLOFF      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic          valid;
    logic          sat;
    logic          dzero;
    logic [DW-1:0] d;
  } dist_word_t;

  typedef struct packed {
    logic          valid;
    logic [PW-1:0] p;
  } pow_word_t;

  function automatic logic [63:0] isqrt_const(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    v = n;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-i) with 32 fraction bits, built by repeated truncated square roots
  function automatic logic [31:0] exp_factor(input int i);
    logic [63:0] c;
    c = 64'h0000_0000_8000_0000;
    for (int j = 1; j <= 16; j++) begin
      if (j <= i) begin
        c = isqrt_const(c << 32);
      end
    end
    return c[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/radial_gradient_pixel_generator_top.sv =====
// Radial gradient pixel generator. Takes one pixel coordinate per clock (start while busy is
// low; busy is never raised) and returns its RGBA word: done is high for one cycle, with
// out_* valid alongside. Throughput is one pixel per clock at all times; the pipeline runs
// through the 32-stage divider, the 16-stage square root, the 16-stage log2 and 16-stage exp2
// chains. Results cannot be held off by the receiver. Registers are written through
// cfg_write/cfg_index/cfg_data and should only change while no pixel is in flight.
`default_nettype none

module radial_gradient_pixel_generator_top import rgpg_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CoordW-1:0]   pixel_column,
  input  wire logic [CoordW-1:0]   pixel_row,
  input  wire logic                cfg_write,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output logic                     done,
  output logic [ColorW-1:0]        out_red,
  output logic [ColorW-1:0]        out_green,
  output logic [ColorW-1:0]        out_blue,
  output logic [ColorW-1:0]        out_alpha
);

  logic [SizeW-1:0]    size_in_use;
  logic [ColorW-1:0]   center_red;
  logic [ColorW-1:0]   center_green;
  logic [ColorW-1:0]   center_blue;
  logic [ColorW-1:0]   edge_red;
  logic [ColorW-1:0]   edge_green;
  logic [ColorW-1:0]   edge_blue;
  logic [FalloffW-1:0] falloff_exponent;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use      <= SizeW'(256);
      center_red       <= 8'hFF;
      center_green     <= 8'hFF;
      center_blue      <= 8'hFF;
      edge_red         <= 8'h00;
      edge_green       <= 8'h00;
      edge_blue        <= 8'h00;
      falloff_exponent <= 16'h1000;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE:         size_in_use      <= cfg_data[SizeW-1:0];
        REG_CENTER_RED:   center_red       <= cfg_data[ColorW-1:0];
        REG_CENTER_GREEN: center_green     <= cfg_data[ColorW-1:0];
        REG_CENTER_BLUE:  center_blue      <= cfg_data[ColorW-1:0];
        REG_EDGE_RED:     edge_red         <= cfg_data[ColorW-1:0];
        REG_EDGE_GREEN:   edge_green       <= cfg_data[ColorW-1:0];
        REG_EDGE_BLUE:    edge_blue        <= cfg_data[ColorW-1:0];
        REG_FALLOFF:      falloff_exponent <= cfg_data[FalloffW-1:0];
      endcase
    end
  end

  dist_word_t dist_w;
  pow_word_t  pw;

  rgpg_dist u_dist (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .size_in_use  (size_in_use),
    .dist_w       (dist_w)
  );

  rgpg_pow u_pow (
    .clk              (clk),
    .rst              (rst),
    .dist_w           (dist_w),
    .falloff_exponent (falloff_exponent),
    .pw               (pw)
  );

  rgpg_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .pw           (pw),
    .center_red   (center_red),
    .center_green (center_green),
    .center_blue  (center_blue),
    .edge_red     (edge_red),
    .edge_green   (edge_green),
    .edge_blue    (edge_blue),
    .done         (done),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha)
  );

endmodule

`default_nettype wire

// ===== sv/rgpg_dist.sv =====
// normalized distance: squares, restoring divide and digit-by-digit square root
`default_nettype none

module rgpg_dist import rgpg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [CoordW-1:0] pixel_column,
  input  wire logic [CoordW-1:0] pixel_row,
  input  wire logic [SizeW-1:0]  size_in_use,
  output dist_word_t             dist_w
);

  localparam logic [SizeW-1:0] SizeMax = SizeW'(MaxSize);

  logic [SizeW-1:0] size_eff;
  always_comb begin
    if (size_in_use == '0) begin
      size_eff = SizeW'(1);
    end else if (size_in_use > SizeMax) begin
      size_eff = SizeMax;
    end else begin
      size_eff = size_in_use;
    end
  end

  // shared size squared, follows the size register
  logic [2*SizeW-1:0] ss_full;
  logic [SsW-1:0]     ss;
  assign ss_full = size_eff * size_eff;
  always_ff @(posedge clk) begin
    ss <= ss_full[SsW-1:0];
  end

  // capture
  logic              v0;
  logic [CoordW-1:0] col0;
  logic [CoordW-1:0] row0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    col0 <= pixel_column;
    row0 <= pixel_row;
  end

  // offsets and squares
  logic signed [NxW-1:0]   nx;
  logic signed [NxW-1:0]   ny;
  logic signed [2*NxW-1:0] nx_sq_full;
  logic signed [2*NxW-1:0] ny_sq_full;
  assign nx = $signed({2'b00, col0, 1'b1}) - $signed({2'b00, size_eff});
  assign ny = $signed({2'b00, row0, 1'b1}) - $signed({2'b00, size_eff});
  assign nx_sq_full = nx * nx;
  assign ny_sq_full = ny * ny;

  logic           v1;
  logic [SqW-1:0] nx_sq;
  logic [SqW-1:0] ny_sq;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    nx_sq <= nx_sq_full[SqW-1:0];
    ny_sq <= ny_sq_full[SqW-1:0];
  end

  // sum and saturation test
  logic [SqW:0] n2;
  assign n2 = {1'b0, nx_sq} + {1'b0, ny_sq};

  logic           dv   [0:DivSteps];
  logic           dsat [0:DivSteps];
  logic [SsW-1:0] dr   [0:DivSteps];
  logic [QW-1:0]  dq   [0:DivSteps];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= v1;
    end
    dsat[0] <= n2 >= (SqW+1)'(ss);
    dr[0]   <= n2[SsW-1:0];
    dq[0]   <= '0;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [SsW:0]   rs;
    logic [SsW-1:0] r_next;
    logic [QW-1:0]  q_next;
    always_comb begin
      rs = {dr[k], 1'b0};
      if (rs >= {1'b0, ss}) begin
        r_next = SsW'(rs - {1'b0, ss});
        q_next = {dq[k][QW-2:0], 1'b1};
      end else begin
        r_next = rs[SsW-1:0];
        q_next = {dq[k][QW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
      dsat[k+1] <= dsat[k];
      dr[k+1]   <= r_next;
      dq[k+1]   <= q_next;
    end
  end

  // one root bit per stage
  logic          sv    [0:SqrtSteps];
  logic          ssat  [0:SqrtSteps];
  logic [DW+1:0] srem  [0:SqrtSteps];
  logic [DW-1:0] sroot [0:SqrtSteps];
  logic [QW-1:0] sbits [0:SqrtSteps];

  assign sv[0]    = dv[DivSteps];
  assign ssat[0]  = dsat[DivSteps];
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sbits[0] = dq[DivSteps];

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    logic [DW+3:0] rem_sh;
    logic [DW+3:0] trial;
    logic [DW+1:0] rem_next;
    logic [DW-1:0] root_next;
    always_comb begin
      rem_sh = {srem[j], sbits[j][QW-1:QW-2]};
      trial  = {2'b00, sroot[j], 2'b01};
      if (rem_sh >= trial) begin
        rem_next  = (DW+2)'(rem_sh - trial);
        root_next = {sroot[j][DW-2:0], 1'b1};
      end else begin
        rem_next  = rem_sh[DW+1:0];
        root_next = {sroot[j][DW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else begin
        sv[j+1] <= sv[j];
      end
      ssat[j+1]  <= ssat[j];
      srem[j+1]  <= rem_next;
      sroot[j+1] <= root_next;
      sbits[j+1] <= {sbits[j][QW-3:0], 2'b00};
    end
  end

  always_comb begin
    dist_w.valid = sv[SqrtSteps];
    dist_w.sat   = ssat[SqrtSteps];
    dist_w.dzero = !ssat[SqrtSteps] && (sroot[SqrtSteps] == '0);
    dist_w.d     = sroot[SqrtSteps];
  end

endmodule

`default_nettype wire

// ===== sv/rgpg_pow.sv =====
// falloff power: log2 by repeated squaring, exponent multiply, exp2 by factor products
`default_nettype none

module rgpg_pow import rgpg_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dist_word_t          dist_w,
  input  wire logic [FalloffW-1:0] falloff_exponent,
  output pow_word_t                pw
);

  // leading one and mantissa alignment
  logic [3:0]       k;
  logic [MantW-1:0] mant_ext;
  logic [MantW-1:0] mant0;
  always_comb begin
    k = 4'd0;
    for (int i = 1; i < DW; i++) begin
      if (dist_w.d[i]) begin
        k = 4'(i);
      end
    end
    mant_ext = {15'd0, dist_w.d};
    mant0    = mant_ext << (5'd30 - {1'b0, k});
  end

  logic             lv   [0:LogSteps];
  logic             lsat [0:LogSteps];
  logic             ldz  [0:LogSteps];
  logic [3:0]       lk   [0:LogSteps];
  logic [MantW-1:0] lm   [0:LogSteps];
  logic [FracW-1:0] lfr  [0:LogSteps];

  always_ff @(posedge clk) begin
    if (rst) begin
      lv[0] <= 1'b0;
    end else begin
      lv[0] <= dist_w.valid;
    end
    lsat[0] <= dist_w.sat;
    ldz[0]  <= dist_w.dzero;
    lk[0]   <= k;
    lm[0]   <= mant0;
    lfr[0]  <= '0;
  end

  // one fraction bit per stage
  for (genvar i = 0; i < LogSteps; i++) begin : g_log
    logic [2*MantW-1:0] prod;
    logic [MantW:0]     sq;
    logic [MantW-1:0]   m_next;
    logic               bit_next;
    always_comb begin
      prod = lm[i] * lm[i];
      sq   = prod[2*MantW-1:30];
      if (sq[MantW]) begin
        m_next   = sq[MantW:1];
        bit_next = 1'b1;
      end else begin
        m_next   = sq[MantW-1:0];
        bit_next = 1'b0;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        lv[i+1] <= 1'b0;
      end else begin
        lv[i+1] <= lv[i];
      end
      lsat[i+1] <= lsat[i];
      ldz[i+1]  <= ldz[i];
      lk[i+1]   <= lk[i];
      lm[i+1]   <= m_next;
      lfr[i+1]  <= {lfr[i][FracW-2:0], bit_next};
    end
  end

  // negated log2
  logic           nv;
  logic           nsat;
  logic           ndz;
  logic [NlW-1:0] nl;
  always_ff @(posedge clk) begin
    if (rst) begin
      nv <= 1'b0;
    end else begin
      nv <= lv[LogSteps];
    end
    nsat <= lsat[LogSteps];
    ndz  <= ldz[LogSteps];
    nl   <= {5'd16 - {1'b0, lk[LogSteps]}, 16'd0} - {5'd0, lfr[LogSteps]};
  end

  // exponent times falloff
  logic [NlW+FalloffW-1:0] eprod;
  assign eprod = nl * falloff_exponent;

  logic            xv   [0:ExpSteps];
  logic            xsat [0:ExpSteps];
  logic            xdz  [0:ExpSteps];
  logic [EW-1:0]   xe   [0:ExpSteps];
  logic [AccW-1:0] xacc [0:ExpSteps];

  always_ff @(posedge clk) begin
    if (rst) begin
      xv[0] <= 1'b0;
    end else begin
      xv[0] <= nv;
    end
    xsat[0] <= nsat;
    xdz[0]  <= ndz;
    xe[0]   <= eprod[EW+11:12];
    xacc[0] <= {1'b1, 32'd0};
  end

  // one fraction bit of the exponent per stage
  for (genvar m = 0; m < ExpSteps; m++) begin : g_exp
    localparam logic [31:0] Factor = exp_factor(m + 1);
    logic [AccW+31:0] prod;
    logic [AccW-1:0]  acc_next;
    always_comb begin
      prod = xacc[m] * Factor;
      if (xe[m][FracW-1-m]) begin
        acc_next = prod[AccW+31:32];
      end else begin
        acc_next = xacc[m];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        xv[m+1] <= 1'b0;
      end else begin
        xv[m+1] <= xv[m];
      end
      xsat[m+1] <= xsat[m];
      xdz[m+1]  <= xdz[m];
      xe[m+1]   <= xe[m];
      xacc[m+1] <= acc_next;
    end
  end

  // whole part shift and special cases
  logic [7:0]      whole;
  logic [AccW-1:0] shifted;
  logic [PW-1:0]   p_exp;
  logic [PW-1:0]   p_next;
  always_comb begin
    whole   = xe[ExpSteps][EW-1:FracW];
    shifted = xacc[ExpSteps] >> whole[4:0];
    if (whole >= 8'd17) begin
      p_exp = '0;
    end else begin
      p_exp = shifted[AccW-1:16];
    end
    if (xdz[ExpSteps]) begin
      p_next = (falloff_exponent == '0) ? POne : '0;
    end else if (xsat[ExpSteps] || falloff_exponent == '0) begin
      p_next = POne;
    end else begin
      p_next = p_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pw.valid <= 1'b0;
    end else begin
      pw.valid <= xv[ExpSteps];
    end
    pw.p <= p_next;
  end

endmodule

`default_nettype wire

// ===== sv/rgpg_blend.sv =====
// color blend and alpha with output register
`default_nettype none

module rgpg_blend import rgpg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pow_word_t         pw,
  input  wire logic [ColorW-1:0] center_red,
  input  wire logic [ColorW-1:0] center_green,
  input  wire logic [ColorW-1:0] center_blue,
  input  wire logic [ColorW-1:0] edge_red,
  input  wire logic [ColorW-1:0] edge_green,
  input  wire logic [ColorW-1:0] edge_blue,
  output logic                   done,
  output logic [ColorW-1:0]      out_red,
  output logic [ColorW-1:0]      out_green,
  output logic [ColorW-1:0]      out_blue,
  output logic [ColorW-1:0]      out_alpha
);

  logic [PW-1:0]          t;
  logic [PW+ColorW:0]     red_sum;
  logic [PW+ColorW:0]     green_sum;
  logic [PW+ColorW:0]     blue_sum;
  logic [PW+ColorW-1:0]   alpha_prod;

  always_comb begin
    t          = POne - pw.p;
    red_sum    = (PW+ColorW+1)'(edge_red) * (PW+ColorW+1)'(pw.p)
               + (PW+ColorW+1)'(center_red) * (PW+ColorW+1)'(t);
    green_sum  = (PW+ColorW+1)'(edge_green) * (PW+ColorW+1)'(pw.p)
               + (PW+ColorW+1)'(center_green) * (PW+ColorW+1)'(t);
    blue_sum   = (PW+ColorW+1)'(edge_blue) * (PW+ColorW+1)'(pw.p)
               + (PW+ColorW+1)'(center_blue) * (PW+ColorW+1)'(t);
    alpha_prod = t * 8'd255;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pw.valid;
    end
    out_red   <= red_sum[23:16];
    out_green <= green_sum[23:16];
    out_blue  <= blue_sum[23:16];
    out_alpha <= alpha_prod[23:16];
  end

  a_word_out: assert property (@(posedge clk) disable iff (rst) pw.valid |=> done)
    else $error("word lost at output stage");
  a_no_extra: assert property (@(posedge clk) disable iff (rst) !pw.valid |=> !done)
    else $error("word invented at output stage");
  a_edge_color: assert property (@(posedge clk) disable iff (rst)
    pw.valid && pw.p == POne |=> out_alpha == '0 && out_red == $past(edge_red))
    else $error("full falloff not edge color");
  a_center: assert property (@(posedge clk) disable iff (rst)
    pw.valid && pw.p == '0 |=> out_alpha == 8'hFF && out_red == $past(center_red))
    else $error("zero falloff not center color");

endmodule

`default_nettype wire
